/* src/skf_pkg.sv */
// ----------------------------------------------------------------------------
// skf_pkg: shared types and constants of the scalar Kalman filter
// Variance format, register indexes and reset values used across the block.
// ----------------------------------------------------------------------------
package skf_pkg;

  // Variances are unsigned Q8.24
  localparam int unsigned VAR_W = 32;

  localparam logic [VAR_W-1:0] VAR_ONE = 32'd16777216;
  localparam logic [VAR_W-1:0] Q_RESET = 32'd167772;
  localparam logic [VAR_W-1:0] R_RESET = 32'd16777216;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_Q = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_R = 1'b1;

  // Handshake between the sequencer and the divider
  typedef struct packed {
    logic start;
  } div_req_t;

  typedef struct packed {
    logic done;
  } div_rsp_t;

endpackage

/* src/skf_div.sv */
// ----------------------------------------------------------------------------
// skf_div: iterative restoring divider for the filter gain
// Computes floor((p << GAIN_FRAC_BITS) / divisor), one quotient bit a cycle.
// ----------------------------------------------------------------------------
module skf_div #(
  parameter int unsigned GAIN_FRAC_BITS = 24
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  skf_pkg::div_req_t                   req_i,
  input  logic [skf_pkg::VAR_W-1:0]           p_i,
  input  logic [skf_pkg::VAR_W:0]             divisor_i,
  output skf_pkg::div_rsp_t                   rsp_o,
  output logic [GAIN_FRAC_BITS:0]             quotient_o
);

  localparam int unsigned VW    = skf_pkg::VAR_W;
  localparam int unsigned STEPS = GAIN_FRAC_BITS + 1;
  localparam int unsigned CNT_W = $clog2(STEPS + 1);

  logic [VW+1:0]         rem_q;
  logic [VW:0]           div_q;
  logic                  nb_q;
  logic [CNT_W-1:0]      cnt_q;
  logic                  busy_q;
  logic                  done_q;
  logic [GAIN_FRAC_BITS:0] quo_q;

  logic [VW+1:0] trial;
  logic          ge;

  // Shift in the next dividend bit: p[0] first, then zeros
  assign trial = {rem_q[VW:0], nb_q};
  assign ge    = (trial >= {1'b0, div_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(STEPS);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      // Top quotient bits are zero since p < 2*(p+r), so start from p >> 1
      rem_q <= {2'b00, 1'b0, p_i[VW-1:1]};
      div_q <= divisor_i;
      nb_q  <= p_i[0];
      quo_q <= '0;
    end else if (busy_q) begin
      nb_q  <= 1'b0;
      rem_q <= ge ? (trial - {1'b0, div_q}) : trial;
      quo_q <= {quo_q[GAIN_FRAC_BITS-1:0], ge};
    end
  end

  assign rsp_o.done = done_q;
  assign quotient_o = quo_q;

endmodule

/* src/skf_mul.sv */
// ----------------------------------------------------------------------------
// skf_mul: shared registered multiplier
// Unsigned product of two operands, registered; used for both update steps.
// ----------------------------------------------------------------------------
module skf_mul #(
  parameter int unsigned A_W = 32,
  parameter int unsigned B_W = 25
) (
  input  logic               clk_i,
  input  logic [A_W-1:0]     a_i,
  input  logic [B_W-1:0]     b_i,
  output logic [A_W+B_W-1:0] prod_o
);

  logic [A_W+B_W-1:0] prod_q;

  always_ff @(posedge clk_i) begin
    prod_q <= (A_W+B_W)'(a_i) * (A_W+B_W)'(b_i);
  end

  assign prod_o = prod_q;

endmodule

/* src/scalar_kalman_filter.sv */
// ----------------------------------------------------------------------------
// scalar_kalman_filter: one-dimensional fixed-point Kalman filter
// Keeps an estimate and its error variance and updates both per sample.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one measurement per transaction (signed Q7.16 sample).
//   m_axis returns one result per measurement: updated estimate, the gain
//   used in this step (Q1.24) and the updated error variance (Q8.24).
//   cfg_we_i writes process noise (index 0) or measurement noise (index 1);
//   each write also reloads the estimate to zero and the variance to one.
// Timing:
//   An accepted measurement steps through PRED, SUM, DIV_START, DIV_WAIT,
//   MUL_K, MUL_P and VAR; s_axis_tready returns once its result is in the
//   output register, so a new measurement waits until then.
//   The gain divider produces one quotient bit per cycle and is the longest
//   step; the multiplier is shared by the estimate and variance updates.
//   s_axis_tready is low while a measurement is in work.
// Reset and stalls:
//   rst_ni clears the noise registers to their defaults, the estimate to
//   zero and the variance to one. The next measurement may be accepted
//   while a result waits on a stalled m_axis; its own result then holds
//   until the output register is free.
// ----------------------------------------------------------------------------
module scalar_kalman_filter #(
  parameter int unsigned SAMPLE_WIDTH   = 24,
  parameter int unsigned GAIN_FRAC_BITS = 24
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // measurement
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  logic [((SAMPLE_WIDTH+7)/8)*8-1:0]    s_axis_tdata,
  // estimate, gain, error_variance
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  output logic [((SAMPLE_WIDTH+GAIN_FRAC_BITS+33+7)/8)*8-1:0] m_axis_tdata,
  input  logic                                 cfg_we_i,
  input  logic [skf_pkg::CFG_IDX_W-1:0]        cfg_idx_i,
  input  logic [skf_pkg::VAR_W-1:0]            cfg_wdata_i
);

  localparam int unsigned SW       = SAMPLE_WIDTH;
  localparam int unsigned GW       = GAIN_FRAC_BITS + 1;
  localparam int unsigned VW       = skf_pkg::VAR_W;
  localparam int unsigned OUT_BITS = SW + GW + VW;
  localparam int unsigned OUT_W    = ((OUT_BITS + 7) / 8) * 8;
  localparam int unsigned MUL_AW   = (SW + 1 > VW) ? SW + 1 : VW;
  localparam logic [GW-1:0] GAIN_ONE = GW'(1) << GAIN_FRAC_BITS;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PRED,
    S_SUM,
    S_DIV_START,
    S_DIV_WAIT,
    S_MUL_K,
    S_MUL_P,
    S_VAR
  } state_e;

  state_e state_q;
  logic   done_q;

  logic [VW-1:0]        q_noise_q;
  logic [VW-1:0]        r_noise_q;
  logic signed [SW-1:0] x_q;
  logic [VW-1:0]        v_q;

  logic signed [SW-1:0] z_q;
  logic [VW-1:0]        p_q;
  logic [VW:0]          sum_q;
  logic [SW:0]          mag_q;
  logic                 neg_q;
  logic [GW-1:0]        gain_q;

  logic                 m_valid_q;
  logic [OUT_BITS-1:0]  m_data_q;

  skf_pkg::div_req_t    div_req;
  skf_pkg::div_rsp_t    div_rsp;
  logic [GW-1:0]        quotient;

  logic [MUL_AW-1:0]    mul_a;
  logic [GW-1:0]        mul_b;
  logic [MUL_AW+GW-1:0] prod;

  logic [VW:0]          pq_sum;
  logic [VW-1:0]        p_pred;
  logic [SW:0]          diff;
  logic [SW:0]          step;
  logic signed [SW+1:0] x_wide;
  logic signed [SW-1:0] x_new;
  logic                 out_free;

  assign pq_sum = {1'b0, v_q} + {1'b0, q_noise_q};
  assign p_pred = pq_sum[VW] ? '1 : pq_sum[VW-1:0];
  assign diff   = {z_q[SW-1], z_q} - {x_q[SW-1], x_q};

  assign step   = prod[GAIN_FRAC_BITS +: SW+1];
  assign x_wide = neg_q ? ($signed({{2{x_q[SW-1]}}, x_q}) - $signed({1'b0, step}))
                        : ($signed({{2{x_q[SW-1]}}, x_q}) + $signed({1'b0, step}));

  always_comb begin
    if (x_wide > $signed((SW+2)'({1'b0, {(SW-1){1'b1}}}))) begin
      x_new = {1'b0, {(SW-1){1'b1}}};
    end else if (x_wide < -$signed((SW+2)'({1'b1, {(SW-1){1'b0}}}))) begin
      x_new = {1'b1, {(SW-1){1'b0}}};
    end else begin
      x_new = x_wide[SW-1:0];
    end
  end

  assign div_req.start = (state_q == S_DIV_START);

  skf_div #(
    .GAIN_FRAC_BITS(GAIN_FRAC_BITS)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (div_req),
    .p_i        (p_q),
    .divisor_i  (sum_q),
    .rsp_o      (div_rsp),
    .quotient_o (quotient)
  );

  // Gain times |z - x| first, then p times (1 - gain)
  assign mul_a = (state_q == S_MUL_K) ? MUL_AW'(mag_q) : MUL_AW'(p_q);
  assign mul_b = (state_q == S_MUL_K) ? gain_q : (GAIN_ONE - gain_q);

  skf_mul #(
    .A_W(MUL_AW),
    .B_W(GW)
  ) u_mul (
    .clk_i  (clk_i),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (prod)
  );

  assign out_free = !m_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      done_q    <= 1'b0;
      m_valid_q <= 1'b0;
      q_noise_q <= skf_pkg::Q_RESET;
      r_noise_q <= skf_pkg::R_RESET;
      x_q       <= '0;
      v_q       <= skf_pkg::VAR_ONE;
    end else begin
      if (m_valid_q && m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (done_q && out_free) begin
            // Result of the last transaction goes to the output register
            m_valid_q <= 1'b1;
            done_q    <= 1'b0;
          end else if (!done_q && s_axis_tvalid) begin
            state_q <= S_PRED;
          end
        end
        S_PRED:      state_q <= S_SUM;
        S_SUM:       state_q <= S_DIV_START;
        S_DIV_START: state_q <= S_DIV_WAIT;
        S_DIV_WAIT: begin
          if (div_rsp.done) begin
            state_q <= S_MUL_K;
          end
        end
        S_MUL_K:     state_q <= S_MUL_P;
        S_MUL_P: begin
          x_q     <= x_new;
          state_q <= S_VAR;
        end
        S_VAR: begin
          v_q     <= prod[GAIN_FRAC_BITS +: VW];
          done_q  <= 1'b1;
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          skf_pkg::CFG_IDX_Q: q_noise_q <= cfg_wdata_i;
          skf_pkg::CFG_IDX_R: r_noise_q <= cfg_wdata_i;
          default: ;
        endcase
        x_q <= '0;
        v_q <= skf_pkg::VAR_ONE;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      z_q <= s_axis_tdata[SW-1:0];
    end
    if (state_q == S_PRED) begin
      p_q   <= p_pred;
      neg_q <= diff[SW];
      mag_q <= diff[SW] ? (~diff + 1'b1) : diff;
    end
    if (state_q == S_SUM) begin
      sum_q <= {1'b0, p_q} + {1'b0, r_noise_q};
    end
    if (state_q == S_DIV_WAIT && div_rsp.done) begin
      gain_q <= (sum_q == '0) ? '0 : quotient;
    end
    if (state_q == S_IDLE && done_q && out_free) begin
      m_data_q <= {v_q, gain_q, x_q};
    end
  end

  assign s_axis_tready = (state_q == S_IDLE) && !done_q;
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = OUT_W'(m_data_q);

endmodule
